>>> sv/qpack_field_line_encoder_top_macros.svh
// Assertion macros for the QPACK field line encoder.
`ifndef QPACK_FIELD_LINE_ENCODER_TOP_MACROS_SVH
`define QPACK_FIELD_LINE_ENCODER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define QFLE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qfle same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define QFLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qfle next-cycle check failed");

`endif

>>> sv/qfle_pkg.sv
// Types and constants shared by the QPACK field line encoder modules.
package qfle_pkg;

   localparam int ValueWidth = 62;
   localparam int ShiftWidth = 64;

   // Encoding selected by one request beat
   typedef enum logic [3:0] {
      ACT_VARINT     = 4'd0,
      ACT_RAW_INT    = 4'd1,
      ACT_SECTION    = 4'd2,
      ACT_INDEXED    = 4'd3,
      ACT_NAME_REF   = 4'd4,
      ACT_LIT_NAME   = 4'd5,
      ACT_PB_INDEXED = 4'd6,
      ACT_PB_NAME    = 4'd7,
      ACT_STRING     = 4'd8
   } qfle_action_type;

   // How the serializer treats a loaded value
   typedef enum logic [1:0] {
      LD_VARINT = 2'd0,
      LD_PREFIX = 2'd1,
      LD_RAW    = 2'd2
   } qfle_kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_FIRST  = 2'd1,
      ST_SECOND = 2'd2
   } qfle_state_type;

   // Load command from the sequencer to the serializer
   typedef struct packed {
      qfle_kind_type         kind;
      logic [ValueWidth-1:0] value;
      logic [3:0]            prefix;
      logic [7:0]            pattern;
   } qfle_load_type;

   // One emitted byte
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } qfle_beat_type;

   // First-byte patterns of the field line heads
   localparam logic [7:0] PatIndexedDyn  = 8'h80;
   localparam logic [7:0] PatIndexedStat = 8'hc0;
   localparam logic [7:0] PatNameRefDyn  = 8'h40;
   localparam logic [7:0] PatNameRefStat = 8'h50;
   localparam logic [7:0] PatLitName     = 8'h20;
   localparam logic [7:0] PatPbIndexed   = 8'h10;
   localparam logic [7:0] PatSign        = 8'h80;
   localparam logic [7:0] PatNone        = 8'h00;

   // Varint length tags
   localparam logic [7:0] TagVar1 = 8'h00;
   localparam logic [7:0] TagVar2 = 8'h40;
   localparam logic [7:0] TagVar4 = 8'h80;
   localparam logic [7:0] TagVar8 = 8'hc0;

   // Prefix widths of the fixed encodings
   localparam logic [3:0] Prefix8 = 4'd8;
   localparam logic [3:0] Prefix7 = 4'd7;
   localparam logic [3:0] Prefix6 = 4'd6;
   localparam logic [3:0] Prefix4 = 4'd4;
   localparam logic [3:0] Prefix3 = 4'd3;
   localparam logic [3:0] Prefix1 = 4'd1;

   // ASCII case folding
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5a;
   localparam logic [7:0] CharLowerBit = 8'h20;

endpackage

>>> sv/qpack_field_line_encoder_top.sv
// Top level of the QPACK field line encoder: sequencer, serializer and output register.
// Each request beat selects one encoding and yields a run of response beats, one byte
// per cycle, with rsp_last on the final byte; actions 9 to 15 are taken and yield
// nothing. A request is accepted only while the block is idle. An item is loaded into
// the serializer as it is accepted and holds the block until its final byte is emitted.
// The byte rate is set by the 64-bit serializer shift register, which moves one
// 7-bit prefix-integer digit or one 8-bit varint byte per cycle; two-integer heads
// reload it between the integers without a gap. The output register holds each byte
// until rsp_ready; the serializer advances in the cycle the held byte is taken, so a
// stall on rsp_ready freezes the run and adds no bubble. There is no clearing pass
// after reset.
`include "qpack_field_line_encoder_top_macros.svh"

module qpack_field_line_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [61:0] req_first_value,
   input  logic [61:0] req_second_value,
   input  logic        req_flag,
   input  logic [3:0]  req_prefix_bits,
   input  logic [7:0]  req_pattern,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   qfle_pkg::qfle_state_type state_ff, state_in;

   logic [61:0] hold_v2_ff, hold_v2_in;
   logic        hold_sign_ff, hold_sign_in;
   logic        has_second_ff, has_second_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                    req_accept;
   logic                    act_ok;
   logic                    act_second;
   logic                    adv;
   logic                    item_end;
   logic                    idle_held;
   logic                    load_en;
   qfle_pkg::qfle_load_type req_load;
   qfle_pkg::qfle_load_type load;
   qfle_pkg::qfle_beat_type beat;
   logic [3:0]              raw_prefix;
   logic [7:0]              str_byte;

   qfle_serializer u_ser (
      .clock   (clock),
      .reset   (reset),
      .load_en (load_en),
      .load    (load),
      .step_en (adv),
      .beat    (beat)
   );

   // Clamp the raw prefix width and fold the string byte
   always_comb begin
      if (req_prefix_bits < qfle_pkg::Prefix1) begin
         raw_prefix = qfle_pkg::Prefix1;
      end else if (req_prefix_bits > qfle_pkg::Prefix8) begin
         raw_prefix = qfle_pkg::Prefix8;
      end else begin
         raw_prefix = req_prefix_bits;
      end
      str_byte = req_byte_in;
      if (req_flag && req_byte_in >= qfle_pkg::CharUpperA
          && req_byte_in <= qfle_pkg::CharUpperZ) begin
         str_byte = req_byte_in | qfle_pkg::CharLowerBit;
      end
   end

   // Decode the action into the first load
   always_comb begin
      act_ok           = 1'b1;
      act_second       = 1'b0;
      req_load.kind    = qfle_pkg::LD_PREFIX;
      req_load.value   = req_first_value;
      req_load.prefix  = qfle_pkg::Prefix8;
      req_load.pattern = qfle_pkg::PatNone;
      case (qfle_pkg::qfle_action_type'(req_action))
         qfle_pkg::ACT_VARINT: begin
            req_load.kind = qfle_pkg::LD_VARINT;
         end
         qfle_pkg::ACT_RAW_INT: begin
            req_load.prefix  = raw_prefix;
            req_load.pattern = req_pattern;
         end
         qfle_pkg::ACT_SECTION: begin
            act_second = 1'b1;
         end
         qfle_pkg::ACT_INDEXED: begin
            req_load.prefix  = qfle_pkg::Prefix6;
            req_load.pattern = req_flag ? qfle_pkg::PatIndexedDyn : qfle_pkg::PatIndexedStat;
         end
         qfle_pkg::ACT_NAME_REF: begin
            act_second       = 1'b1;
            req_load.prefix  = qfle_pkg::Prefix4;
            req_load.pattern = req_flag ? qfle_pkg::PatNameRefDyn : qfle_pkg::PatNameRefStat;
         end
         qfle_pkg::ACT_LIT_NAME: begin
            req_load.prefix  = qfle_pkg::Prefix3;
            req_load.pattern = qfle_pkg::PatLitName;
         end
         qfle_pkg::ACT_PB_INDEXED: begin
            req_load.prefix  = qfle_pkg::Prefix4;
            req_load.pattern = qfle_pkg::PatPbIndexed;
         end
         qfle_pkg::ACT_PB_NAME: begin
            act_second      = 1'b1;
            req_load.prefix = qfle_pkg::Prefix3;
         end
         qfle_pkg::ACT_STRING: begin
            req_load.kind    = qfle_pkg::LD_RAW;
            req_load.pattern = str_byte;
         end
         default: begin
            act_ok = 1'b0;
         end
      endcase
   end

   // Handshake and serializer control
   always_comb begin
      req_ready  = (state_ff == qfle_pkg::ST_IDLE);
      req_accept = req_valid && req_ready;
      idle_held  = (state_ff == qfle_pkg::ST_IDLE) && rsp_valid_ff;
      adv        = (state_ff != qfle_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      item_end   = adv && beat.last
                   && !(state_ff == qfle_pkg::ST_FIRST && has_second_ff);
      load_en    = (req_accept && act_ok)
                   || (adv && beat.last && state_ff == qfle_pkg::ST_FIRST && has_second_ff);
      if (state_ff == qfle_pkg::ST_IDLE) begin
         load = req_load;
      end else begin
         load.kind    = qfle_pkg::LD_PREFIX;
         load.value   = hold_v2_ff;
         load.prefix  = qfle_pkg::Prefix7;
         load.pattern = hold_sign_ff ? qfle_pkg::PatSign : qfle_pkg::PatNone;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qfle_pkg::ST_IDLE: begin
            if (req_accept && act_ok) begin
               state_in = qfle_pkg::ST_FIRST;
            end
         end
         qfle_pkg::ST_FIRST: begin
            if (adv && beat.last) begin
               state_in = has_second_ff ? qfle_pkg::ST_SECOND : qfle_pkg::ST_IDLE;
            end
         end
         qfle_pkg::ST_SECOND: begin
            if (adv && beat.last) begin
               state_in = qfle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qfle_pkg::ST_IDLE;
         end
      endcase
   end

   // Capture the second integer and fill the output register
   always_comb begin
      hold_v2_in    = hold_v2_ff;
      hold_sign_in  = hold_sign_ff;
      has_second_in = has_second_ff;
      if (req_accept) begin
         hold_v2_in    = req_second_value;
         hold_sign_in  = req_flag
                         && (qfle_pkg::qfle_action_type'(req_action) == qfle_pkg::ACT_SECTION);
         has_second_in = act_second;
      end
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = beat.data;
         rsp_last_in  = beat.last && !(state_ff == qfle_pkg::ST_FIRST && has_second_ff);
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= qfle_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         has_second_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         has_second_ff <= has_second_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_v2_ff   <= hold_v2_in;
      hold_sign_ff <= hold_sign_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // A held beat while idle always closes its run
   `QFLE_ASSERT_SAME(a_idle_last, clock, reset, idle_held, rsp_last_ff)
   // A known action starts a run
   `QFLE_ASSERT_NEXT(a_start, clock, reset, req_accept && act_ok, state_ff == qfle_pkg::ST_FIRST)
   // The closing byte returns the sequencer to idle
   `QFLE_ASSERT_NEXT(a_end, clock, reset, item_end, state_ff == qfle_pkg::ST_IDLE)

endmodule

>>> sv/qfle_serializer.sv
// Digit-serial shift register that emits one encoded integer or raw byte per cycle while step_en is high.
module qfle_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_en,
   input  qfle_pkg::qfle_load_type load,
   input  logic                  step_en,
   output qfle_pkg::qfle_beat_type beat
);

   logic [qfle_pkg::ShiftWidth-1:0] sr_ff, sr_in;
   logic [7:0]                      first_byte_ff, first_byte_in;
   logic                            first_ff, first_in;
   logic                            tail_ff, tail_in;
   logic                            varint_ff, varint_in;
   logic [3:0]                      cnt_ff, cnt_in;

   logic [7:0] limit;
   logic       single;
   logic       more;

   // Decode the load: prefix limit, short form test, and whether more digits remain
   always_comb begin
      limit  = 8'hff >> (4'd8 - load.prefix);
      single = (load.value[qfle_pkg::ValueWidth-1:8] == '0) && (load.value[7:0] < limit);
      more   = |sr_ff[qfle_pkg::ShiftWidth-1:7];
   end

   // Present the current byte
   always_comb begin
      if (varint_ff) begin
         beat.data = sr_ff[qfle_pkg::ShiftWidth-1:qfle_pkg::ShiftWidth-8]
                   | (first_ff ? first_byte_ff : 8'h00);
         beat.last = (cnt_ff == 4'd1);
      end else if (first_ff) begin
         beat.data = first_byte_ff;
         beat.last = !tail_ff;
      end else begin
         beat.data = {more, sr_ff[6:0]};
         beat.last = !more;
      end
   end

   // Load a new integer or advance one digit
   always_comb begin
      sr_in         = sr_ff;
      first_byte_in = first_byte_ff;
      first_in      = first_ff;
      tail_in       = tail_ff;
      varint_in     = varint_ff;
      cnt_in        = cnt_ff;
      if (load_en) begin
         first_in = 1'b1;
         case (load.kind)
            qfle_pkg::LD_VARINT: begin
               varint_in = 1'b1;
               tail_in   = 1'b0;
               if (load.value[qfle_pkg::ValueWidth-1:6] == '0) begin
                  cnt_in        = 4'd1;
                  first_byte_in = qfle_pkg::TagVar1;
                  sr_in         = {load.value[7:0], 56'h0};
               end else if (load.value[qfle_pkg::ValueWidth-1:14] == '0) begin
                  cnt_in        = 4'd2;
                  first_byte_in = qfle_pkg::TagVar2;
                  sr_in         = {load.value[15:0], 48'h0};
               end else if (load.value[qfle_pkg::ValueWidth-1:30] == '0) begin
                  cnt_in        = 4'd4;
                  first_byte_in = qfle_pkg::TagVar4;
                  sr_in         = {load.value[31:0], 32'h0};
               end else begin
                  cnt_in        = 4'd8;
                  first_byte_in = qfle_pkg::TagVar8;
                  sr_in         = {2'b00, load.value};
               end
            end
            qfle_pkg::LD_PREFIX: begin
               varint_in     = 1'b0;
               cnt_in        = 4'd0;
               tail_in       = !single;
               first_byte_in = load.pattern | (single ? load.value[7:0] : limit);
               sr_in         = {2'b00, load.value
                               - {{(qfle_pkg::ValueWidth-8){1'b0}}, limit}};
            end
            default: begin
               varint_in     = 1'b0;
               cnt_in        = 4'd0;
               tail_in       = 1'b0;
               first_byte_in = load.pattern;
               sr_in         = '0;
            end
         endcase
      end else if (step_en) begin
         first_in = 1'b0;
         if (varint_ff) begin
            sr_in  = {sr_ff[qfle_pkg::ShiftWidth-9:0], 8'h00};
            cnt_in = cnt_ff - 4'd1;
         end else if (!first_ff) begin
            sr_in = {7'h00, sr_ff[qfle_pkg::ShiftWidth-1:7]};
         end
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= 1'b0;
         tail_ff   <= 1'b0;
         varint_ff <= 1'b0;
         cnt_ff    <= 4'd0;
      end else begin
         first_ff  <= first_in;
         tail_ff   <= tail_in;
         varint_ff <= varint_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff         <= sr_in;
      first_byte_ff <= first_byte_in;
   end

endmodule

>>> verif/tb_qpack_field_line_encoder_top.sv
// Self-checking testbench for the QPACK field line encoder top level.
module tb_qpack_field_line_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Expected output bytes, predicted from each accepted request beat
   class qfle_scoreboard;
      qfle_pkg::qfle_beat_type pending_bytes[$];
      qfle_pkg::qfle_beat_type item_bytes[$];
      int unsigned   errors;
      int unsigned   bytes_checked;
      int unsigned   action_hits[16];

      function new();
         errors = 0;
         bytes_checked = 0;
         foreach (action_hits[i]) action_hits[i] = 0;
      endfunction

      function void add_byte(logic [7:0] data);
         qfle_pkg::qfle_beat_type b;
         b.data = data;
         b.last = 1'b0;
         item_bytes.push_back(b);
      endfunction

      // Emit one prefix integer: first byte carries the pattern, then 7-bit digits
      function void add_prefix_int(logic [63:0] value, int unsigned prefix,
                                   logic [7:0] first_bits);
         logic [63:0] limit;
         logic [63:0] rest;
         limit = (64'd1 << prefix) - 64'd1;
         if (value < limit) begin
            add_byte(first_bits | value[7:0]);
         end else begin
            add_byte(first_bits | limit[7:0]);
            rest = value - limit;
            while (rest >= 64'd128) begin
               add_byte(8'h80 | {1'b0, rest[6:0]});
               rest = rest >> 7;
            end
            add_byte(rest[7:0]);
         end
      endfunction

      // Emit a QUIC varint: length tag in the top two bits of the first byte
      function void add_varint(logic [63:0] value);
         int         nbytes;
         logic [7:0] tag;
         logic [7:0] b;
         if (value <= 64'd63) begin
            nbytes = 1;
            tag = qfle_pkg::TagVar1;
         end else if (value <= 64'd16383) begin
            nbytes = 2;
            tag = qfle_pkg::TagVar2;
         end else if (value <= 64'd1073741823) begin
            nbytes = 4;
            tag = qfle_pkg::TagVar4;
         end else begin
            nbytes = 8;
            tag = qfle_pkg::TagVar8;
         end
         for (int i = nbytes - 1; i >= 0; i--) begin
            b = 8'((value >> (8 * i)) & 64'hff);
            if (i == nbytes - 1) b = b | tag;
            add_byte(b);
         end
      endfunction

      // Predict the bytes of one accepted request beat
      function void note_request(logic [3:0] action, logic [61:0] first_value,
                                 logic [61:0] second_value, logic flag,
                                 logic [3:0] prefix_bits, logic [7:0] pattern,
                                 logic [7:0] byte_in);
         logic [63:0] v1;
         logic [63:0] v2;
         int unsigned pbits;
         logic [7:0]  ch;
         v1 = {2'b00, first_value};
         v2 = {2'b00, second_value};
         item_bytes.delete();
         action_hits[action]++;
         case (action)
            qfle_pkg::ACT_VARINT: add_varint(v1);
            qfle_pkg::ACT_RAW_INT: begin
               pbits = prefix_bits;
               if (pbits < 1) pbits = 1;
               if (pbits > 8) pbits = 8;
               add_prefix_int(v1, pbits, pattern);
            end
            qfle_pkg::ACT_SECTION: begin
               add_prefix_int(v1, 8, qfle_pkg::PatNone);
               add_prefix_int(v2, 7, flag ? qfle_pkg::PatSign : qfle_pkg::PatNone);
            end
            qfle_pkg::ACT_INDEXED: begin
               add_prefix_int(v1, 6, flag ? qfle_pkg::PatIndexedDyn
                                          : qfle_pkg::PatIndexedStat);
            end
            qfle_pkg::ACT_NAME_REF: begin
               add_prefix_int(v1, 4, flag ? qfle_pkg::PatNameRefDyn
                                          : qfle_pkg::PatNameRefStat);
               add_prefix_int(v2, 7, qfle_pkg::PatNone);
            end
            qfle_pkg::ACT_LIT_NAME: add_prefix_int(v1, 3, qfle_pkg::PatLitName);
            qfle_pkg::ACT_PB_INDEXED: add_prefix_int(v1, 4, qfle_pkg::PatPbIndexed);
            qfle_pkg::ACT_PB_NAME: begin
               add_prefix_int(v1, 3, qfle_pkg::PatNone);
               add_prefix_int(v2, 7, qfle_pkg::PatNone);
            end
            qfle_pkg::ACT_STRING: begin
               ch = byte_in;
               if (flag && ch >= qfle_pkg::CharUpperA && ch <= qfle_pkg::CharUpperZ)
                  ch = ch | qfle_pkg::CharLowerBit;
               add_byte(ch);
            end
            default: ;
         endcase
         // Mark the final byte of the run, then queue the run
         if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
         foreach (item_bytes[i]) pending_bytes.push_back(item_bytes[i]);
      endfunction

      // Compare one accepted response beat against the oldest expected byte
      function void check_byte(logic [7:0] data, logic last);
         qfle_pkg::qfle_beat_type want;
         if (pending_bytes.size() == 0) begin
            $display("%0.3f ns: unexpected byte, expected none, got %02h last %0b",
                     $realtime, data, last);
            errors++;
            return;
         end
         want = pending_bytes.pop_front();
         bytes_checked++;
         if (data !== want.data) begin
            $display("%0.3f ns: out_byte mismatch, expected %02h, got %02h",
                     $realtime, want.data, data);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0.3f ns: last mismatch, expected %0b, got %0b",
                     $realtime, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_action = '0;
   logic [61:0] req_first_value = '0;
   logic [61:0] req_second_value = '0;
   logic        req_flag = 1'b0;
   logic [3:0]  req_prefix_bits = '0;
   logic [7:0]  req_pattern = '0;
   logic [7:0]  req_byte_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   qfle_scoreboard sb;
   bit             quiet = 1'b0;
   int unsigned    items_sent = 0;

   localparam logic [61:0] MaxValue = 62'h3fff_ffff_ffff_ffff;

   qpack_field_line_encoder_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .req_flag         (req_flag),
      .req_prefix_bits  (req_prefix_bits),
      .req_pattern      (req_pattern),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Random 62-bit value, weighted toward small sizes and prefix boundaries
   function automatic logic [61:0] pick_value();
      logic [63:0] raw;
      logic [63:0] mask;
      int unsigned sel;
      int unsigned w;
      raw = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel >= 85) begin
         raw = (64'd1 << $urandom_range(1, 62)) + 64'($urandom_range(0, 3)) - 64'd2;
         return raw[61:0];
      end
      if (sel < 45) w = $urandom_range(0, 8);
      else if (sel < 70) w = $urandom_range(9, 20);
      else w = $urandom_range(21, 62);
      mask = (64'd1 << w) - 64'd1;
      raw = raw & mask;
      return raw[61:0];
   endfunction

   // Drive one request beat after a random gap and hold it until accepted
   task automatic send_item(logic [3:0] action, logic [61:0] v1, logic [61:0] v2,
                            logic flag, logic [3:0] pbits, logic [7:0] pat,
                            logic [7:0] ch);
      int unsigned gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_first_value  <= v1;
      req_second_value <= v2;
      req_flag         <= flag;
      req_prefix_bits  <= pbits;
      req_pattern      <= pat;
      req_byte_in      <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(action, v1, v2, flag, pbits, pat, ch);
      items_sent++;
   endtask

   // Drop the request and hold off until every predicted byte has come out
   task automatic drain_output();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bytes.size() != 0) @(posedge clock);
   endtask

   // Build one random request; unused action codes show up now and then
   task automatic send_random_item(output bit counted);
      logic [3:0]  action;
      logic [7:0]  ch;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) action = 4'($urandom_range(9, 15));
      else action = 4'($urandom_range(0, 8));
      if ($urandom_range(0, 1)) ch = 8'($urandom_range(8'h3f, 8'h5c));
      else ch = 8'($urandom_range(0, 255));
      send_item(action, pick_value(), pick_value(), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), ch);
      counted = (action <= qfle_pkg::ACT_STRING);
   endtask

   // Accept response beats with random stalls; no stalls during quiet stretches
   initial begin : rsp_stall_gen
      int unsigned stall;
      forever begin
         stall = quiet ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Check every accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_byte(rsp_out_byte, rsp_last);
   end

   // Bound the run
   initial begin
      #15ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : main_seq
      int unsigned useful;
      int unsigned unused;
      bit          counted;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Varint length boundaries
      send_item(qfle_pkg::ACT_VARINT, 62'd0, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_VARINT, 62'd63, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_VARINT, 62'd64, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_VARINT, 62'd16384, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_VARINT, 62'd1073741824, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_VARINT, MaxValue, MaxValue, 1'b1, 4'd15, 8'hff, 8'hff);
      // Raw prefix: width zero and above eight clamp, exact limit, overlapping pattern
      send_item(qfle_pkg::ACT_RAW_INT, 62'd1, 62'd0, 1'b0, 4'd0, 8'hfe, 8'h00);
      send_item(qfle_pkg::ACT_RAW_INT, 62'd255, 62'd0, 1'b0, 4'd15, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_RAW_INT, 62'd254, 62'd0, 1'b0, 4'd8, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_RAW_INT, MaxValue, 62'd0, 1'b0, 4'd1, 8'hff, 8'h00);
      send_item(qfle_pkg::ACT_RAW_INT, 62'd200, 62'd0, 1'b0, 4'd5, 8'hff, 8'h00);
      // Section prefix with both delta signs
      send_item(qfle_pkg::ACT_SECTION, 62'd0, 62'd126, 1'b1, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_SECTION, 62'd255, 62'd127, 1'b0, 4'd0, 8'h00, 8'h00);
      // Field line heads at their prefix limits, static and dynamic
      send_item(qfle_pkg::ACT_INDEXED, 62'd62, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_INDEXED, 62'd63, 62'd0, 1'b1, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_NAME_REF, MaxValue, MaxValue, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_NAME_REF, 62'd14, 62'd0, 1'b1, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_LIT_NAME, 62'd7, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_PB_INDEXED, 62'd15, 62'd0, 1'b0, 4'd0, 8'h00, 8'h00);
      send_item(qfle_pkg::ACT_PB_NAME, 62'd7, 62'd128, 1'b0, 4'd0, 8'h00, 8'h00);
      // String bytes: case folding edges and no-fold request
      send_item(qfle_pkg::ACT_STRING, 62'd0, 62'd0, 1'b1, 4'd0, 8'h00, 8'h41);
      send_item(qfle_pkg::ACT_STRING, 62'd0, 62'd0, 1'b1, 4'd0, 8'h00, 8'h5a);
      send_item(qfle_pkg::ACT_STRING, 62'd0, 62'd0, 1'b1, 4'd0, 8'h00, 8'h40);
      send_item(qfle_pkg::ACT_STRING, 62'd0, 62'd0, 1'b0, 4'd0, 8'h00, 8'h51);
      // Unused action codes produce nothing
      send_item(4'd9, 62'd5, 62'd5, 1'b1, 4'd3, 8'h0f, 8'h41);
      send_item(4'd15, MaxValue, MaxValue, 1'b1, 4'd15, 8'hff, 8'hff);
      drain_output();

      // Random traffic, with a stretch of back-to-back beats and a mid-run drain
      useful = 0;
      while (useful < 420) begin
         quiet = (useful >= 150 && useful < 230);
         if (useful == 300) drain_output();
         send_random_item(counted);
         if (counted) useful++;
      end
      quiet = 1'b0;
      drain_output();
      repeat (40) @(posedge clock);

      unused = 0;
      foreach (sb.action_hits[i]) begin
         if (i > qfle_pkg::ACT_STRING) unused += sb.action_hits[i];
      end
      $display("Covered %0d request beats (%0d with unused codes), %0d bytes checked",
               items_sent, unused, sb.bytes_checked);
      $display("All nine encodings exercised with random stalls; %0d mismatches",
               sb.errors);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
